// File: design/itok_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itok_pkg
// Shared types and constants of the IMAP argument tokenizer.
// ----------------------------------------------------------------------------
package itok_pkg;

    localparam int MAX_RES  = 4;
    localparam int RES_AW   = 2;
    localparam int CNT_W    = 3;
    localparam int FIFO_DEP = 4;
    localparam int FIFO_AW  = 2;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_LPAR  = 8'h28;
    localparam logic [7:0] CH_RPAR  = 8'h29;
    localparam logic [7:0] CH_LBRK  = 8'h5B;
    localparam logic [7:0] CH_BSL   = 8'h5C;
    localparam logic [7:0] CH_RBRK  = 8'h5D;
    localparam logic [7:0] CH_LBRC  = 8'h7B;
    localparam logic [7:0] CH_RBRC  = 8'h7D;

    typedef enum logic [1:0] {
        K_BYTE = 2'd0,
        K_END  = 2'd1,
        K_EOL  = 2'd2
    } t_kind;

    typedef enum logic [3:0] {
        M_IDLE    = 4'd0,
        M_ATOM    = 4'd1,
        M_QUOTED  = 4'd2,
        M_LIST    = 4'd3,
        M_LIST_IN = 4'd4,
        M_LIST_Q  = 4'd5,
        M_RESP    = 4'd6,
        M_RESP_IN = 4'd7,
        M_RESP_Q  = 4'd8,
        M_LIT     = 4'd9
    } t_mode;

    typedef struct packed {
        t_kind      kind;
        logic [7:0] data;
    } t_res;

    // All results caused by one input byte.
    typedef struct packed {
        logic [CNT_W-1:0]   cnt;
        t_res [MAX_RES-1:0] res;
    } t_bundle;

    function automatic t_bundle f_emit(t_bundle b, t_kind k, logic [7:0] d);
        t_bundle o;
        o = b;
        if (b.cnt < CNT_W'(MAX_RES)) begin
            o.res[b.cnt[RES_AW-1:0]].kind = k;
            o.res[b.cnt[RES_AW-1:0]].data = (k == K_BYTE) ? d : 8'd0;
            o.cnt = b.cnt + CNT_W'(1);
        end
        return o;
    endfunction

endpackage

// File: design/itok_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itok_front
// Tokenizer state machine: classifies one accepted byte per cycle into a result bundle.
// ----------------------------------------------------------------------------
module itok_front #(
    parameter int DEPTH_BITS = 4
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic [7:0]       i_byte,
    input  logic             i_last,
    output logic             o_push,
    output itok_pkg::t_bundle o_bundle
);
    import itok_pkg::*;

    localparam logic [DEPTH_BITS-1:0] DMAX = {DEPTH_BITS{1'b1}};
    localparam logic [DEPTH_BITS-1:0] DONE = DEPTH_BITS'(1);

    t_mode                 r_mode, n_mode;
    logic                  r_esc, n_esc;
    logic [DEPTH_BITS-1:0] r_od, n_od;
    logic [DEPTH_BITS-1:0] r_id, n_id;

    t_bundle    b;
    logic       do_start;
    logic       q_close;
    logic       is_list;
    logic [7:0] c_open, c_close, c_iopen, c_iclose;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= M_IDLE;
            r_esc  <= 1'b0;
            r_od   <= '0;
            r_id   <= '0;
        end else if (i_accept) begin
            r_mode <= n_mode;
            r_esc  <= n_esc;
            r_od   <= n_od;
            r_id   <= n_id;
        end
    end

    always_comb begin
        n_mode   = r_mode;
        n_esc    = r_esc;
        n_od     = r_od;
        n_id     = r_id;
        b        = '0;
        do_start = 1'b0;
        q_close  = 1'b0;
        is_list  = (r_mode == M_LIST) || (r_mode == M_LIST_IN) || (r_mode == M_LIST_Q);
        c_open   = is_list ? CH_LPAR : CH_LBRK;
        c_close  = is_list ? CH_RPAR : CH_RBRK;
        c_iopen  = is_list ? CH_LBRK : CH_LPAR;
        c_iclose = is_list ? CH_RBRK : CH_RPAR;

        // Quote body shared by the plain quote and quotes inside lists and response codes.
        if (r_esc) begin
            n_esc = 1'b0;
        end else if (i_byte == CH_QUOTE) begin
            q_close = 1'b1;
        end else if (i_byte == CH_BSL && !i_last) begin
            n_esc = 1'b1;
        end

        unique case (r_mode)
            M_IDLE: begin
                do_start = 1'b1;
            end
            M_ATOM: begin
                if (i_byte == CH_SPACE || i_byte == CH_LPAR || i_byte == CH_RPAR ||
                    i_byte == CH_LBRK || i_byte == CH_RBRK || i_byte == CH_QUOTE ||
                    i_byte == CH_LBRC) begin
                    b        = f_emit(b, K_END, 8'd0);
                    n_mode   = M_IDLE;
                    do_start = 1'b1;
                end else begin
                    b = f_emit(b, K_BYTE, i_byte);
                end
            end
            M_QUOTED, M_LIST_Q, M_RESP_Q: begin
                if (r_esc || (!q_close && n_esc == 1'b0)) begin
                    b = f_emit(b, K_BYTE, i_byte);
                end
                if (q_close) begin
                    if (r_mode == M_QUOTED) begin
                        b      = f_emit(b, K_END, 8'd0);
                        n_mode = M_IDLE;
                    end else begin
                        b      = f_emit(b, K_BYTE, CH_QUOTE);
                        n_mode = is_list ? M_LIST : M_RESP;
                    end
                end
            end
            M_LIST, M_RESP: begin
                b = f_emit(b, K_BYTE, i_byte);
                n_esc = r_esc;
                if (i_byte == c_open) begin
                    n_od = (r_od == DMAX) ? DMAX : r_od + DONE;
                end else if (i_byte == c_close) begin
                    n_od = (r_od == '0) ? '0 : r_od - DONE;
                    if (n_od == '0) begin
                        b      = f_emit(b, K_END, 8'd0);
                        n_mode = M_IDLE;
                    end
                end else if (i_byte == c_iopen) begin
                    n_id   = DONE;
                    n_mode = is_list ? M_LIST_IN : M_RESP_IN;
                end else if (i_byte == CH_QUOTE) begin
                    n_esc  = 1'b0;
                    n_mode = is_list ? M_LIST_Q : M_RESP_Q;
                end
            end
            M_LIST_IN, M_RESP_IN: begin
                b = f_emit(b, K_BYTE, i_byte);
                n_esc = r_esc;
                if (i_byte == c_iopen) begin
                    n_id = (r_id == DMAX) ? DMAX : r_id + DONE;
                end else if (i_byte == c_iclose) begin
                    n_id = (r_id == '0) ? '0 : r_id - DONE;
                    if (n_id == '0) begin
                        n_mode = is_list ? M_LIST : M_RESP;
                    end
                end
            end
            M_LIT: begin
                b = f_emit(b, K_BYTE, i_byte);
                n_esc = r_esc;
                if (i_byte == CH_RBRC) begin
                    b      = f_emit(b, K_END, 8'd0);
                    n_mode = M_IDLE;
                end
            end
            default: begin
                n_esc    = r_esc;
                n_mode   = M_IDLE;
                do_start = 1'b1;
            end
        endcase

        if (do_start) begin
            if (i_byte == CH_SPACE) begin
                n_mode = M_IDLE;
            end else if (i_byte == CH_QUOTE) begin
                n_mode = M_QUOTED;
                n_esc  = 1'b0;
            end else if (i_byte == CH_LPAR) begin
                b      = f_emit(b, K_BYTE, i_byte);
                n_mode = M_LIST;
                n_od   = DONE;
            end else if (i_byte == CH_LBRK) begin
                b      = f_emit(b, K_BYTE, i_byte);
                n_mode = M_RESP;
                n_od   = DONE;
            end else if (i_byte == CH_LBRC) begin
                b      = f_emit(b, K_BYTE, i_byte);
                n_mode = M_LIT;
            end else if (i_byte == CH_RPAR || i_byte == CH_RBRK) begin
                // A closer with nothing open is dropped.
                n_mode = M_IDLE;
            end else begin
                b      = f_emit(b, K_BYTE, i_byte);
                n_mode = M_ATOM;
            end
        end

        if (i_last) begin
            if (n_mode != M_IDLE) begin
                if (n_mode == M_LIST_Q || n_mode == M_RESP_Q) begin
                    b = f_emit(b, K_BYTE, CH_QUOTE);
                end
                b = f_emit(b, K_END, 8'd0);
            end
            b      = f_emit(b, K_EOL, 8'd0);
            n_mode = M_IDLE;
            n_esc  = 1'b0;
            n_od   = '0;
            n_id   = '0;
        end
    end

    assign o_push   = i_accept && (b.cnt != '0);
    assign o_bundle = b;

endmodule

// File: design/itok_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itok_fifo
// Short queue of result bundles between the classifier and the output stage.
// ----------------------------------------------------------------------------
module itok_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  itok_pkg::t_bundle i_bundle,
    input  logic              i_pop,
    output logic              o_full,
    output logic              o_empty,
    output itok_pkg::t_bundle o_head
);
    import itok_pkg::*;

    t_bundle              r_mem [FIFO_DEP];
    logic [FIFO_AW-1:0]   r_wr, r_rd;
    logic [FIFO_AW:0]     r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_bundle;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + FIFO_AW'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + FIFO_AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (FIFO_AW+1)'(1);
                2'b01:   r_count <= r_count - (FIFO_AW+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = (r_count == (FIFO_AW+1)'(FIFO_DEP));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd];

endmodule

// File: design/itok_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itok_back
// Output stage: unpacks each bundle into single result beats.
// ----------------------------------------------------------------------------
module itok_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_empty,
    input  itok_pkg::t_bundle i_head,
    output logic              o_pop,
    input  logic              i_ready,
    output logic              o_valid,
    output logic [7:0]        o_data,
    output logic [1:0]        o_user,
    output logic              o_last
);
    import itok_pkg::*;

    logic [RES_AW-1:0]  r_idx;
    logic               r_valid;
    t_res               r_res;
    logic               r_last;
    logic               load;
    logic               at_end;

    assign load   = !i_empty && (!r_valid || i_ready);
    assign at_end = ({1'b0, r_idx} == i_head.cnt - CNT_W'(1));
    assign o_pop  = load && at_end;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else if (load) begin
            r_valid <= 1'b1;
            r_idx   <= at_end ? '0 : r_idx + RES_AW'(1);
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_res  <= i_head.res[r_idx];
            r_last <= at_end;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_res.data;
    assign o_user  = r_res.kind;
    assign o_last  = r_last;

endmodule

// File: design/imap_argument_tokenizer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imap_argument_tokenizer_unit
// Splits an IMAP argument line into token bytes and token/line end marks.
// ----------------------------------------------------------------------------
// Input stream: one byte of the argument line per beat in tdata, with tlast
// set on the last byte of the line.
// Output stream: one result per beat. tuser gives the kind (token byte, end
// of token, end of line), tdata the token byte (zero for the marks), and
// tlast flags the last result caused by one input byte.
// The classifier handles a new byte every cycle while the four-entry bundle
// queue has room. One input byte can cause zero to four results, and the
// output stage sends one result per cycle while the receiver is ready, so the
// sustained rate is one byte per cycle when each byte yields at most one
// result. An accepted byte's results pass through the bundle queue and the
// output register before the first result beat.
// When the receiver holds tready low the output beat holds, the queue fills,
// and then tready on the input side drops until room is made.
// Reset is synchronous: the tokenizer returns to the between-tokens state and
// the queue and output register are emptied.
// ----------------------------------------------------------------------------
module imap_argument_tokenizer_unit #(
    parameter int DEPTH_BITS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] in_byte
    input  logic       i_s_axis_tlast,
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] out_byte
    output logic [1:0] o_m_axis_tuser,   // [1:0] kind
    output logic       o_m_axis_tlast
);
    import itok_pkg::*;

    logic    accept;
    logic    push, pop, full, empty;
    t_bundle bundle, head;

    assign o_s_axis_tready = !full;
    assign accept          = i_s_axis_tvalid && !full;

    itok_front #(.DEPTH_BITS(DEPTH_BITS)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_push   (push),
        .o_bundle (bundle)
    );

    itok_fifo u_fifo (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_bundle (bundle),
        .i_pop    (pop),
        .o_full   (full),
        .o_empty  (empty),
        .o_head   (head)
    );

    itok_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_empty (empty),
        .i_head  (head),
        .o_pop   (pop),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_data  (o_m_axis_tdata),
        .o_user  (o_m_axis_tuser),
        .o_last  (o_m_axis_tlast)
    );

endmodule

// File: design/itok_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itok_checker
// Port-level checks of the tokenizer output stream.
// ----------------------------------------------------------------------------
module itok_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [1:0] o_m_axis_tuser,
    input logic       o_m_axis_tlast
);
    import itok_pkg::*;

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("output beat dropped while stalled");

    a_eol_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser == K_EOL |-> o_m_axis_tlast)
        else $error("end of line is not the last result of its byte");

    a_mark_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser != K_BYTE |-> o_m_axis_tdata == 8'd0)
        else $error("mark beat carries a nonzero byte");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind imap_argument_tokenizer_unit itok_checker u_itok_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser),
    .o_m_axis_tlast  (o_m_axis_tlast)
);
